>>> design/priority_round_robin_task_scheduler_assert.svh
// Assertion macros for the task scheduler checker.
// No dependencies; included by the checker file.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
// same-cycle implication
`define PRRTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");
// next-cycle implication
`define PRRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");
`endif

>>> design/prrts_pkg.sv
// Shared types and codes for the task scheduler.
// No dependencies.
package prrts_pkg;
   localparam logic [1:0] ST_READY   = 2'd0;
   localparam logic [1:0] ST_BLOCKED = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_EXITING = 2'd3;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_YIELD  = 3'd3;
   localparam logic [2:0] OP_SLEEP  = 3'd4;
   localparam logic [2:0] OP_EXIT   = 3'd5;

   localparam logic [1:0] PRIO_HIGH = 2'd0;
   localparam logic [1:0] PRIO_LOW  = 2'd2;

   localparam logic [1:0] CSR_SLICE_HIGH   = 2'd0;
   localparam logic [1:0] CSR_SLICE_NORMAL = 2'd1;
   localparam logic [1:0] CSR_SLICE_LOW    = 2'd2;

   typedef struct packed {
      logic        used;
      logic [7:0]  task_id;
      logic [1:0]  prio;
      logic [1:0]  status;
      logic [31:0] count;
   } slot_type;

   typedef struct packed {
      logic shift;
      logic dec;
   } cell_ctl_type;
endpackage

>>> design/priority_round_robin_task_scheduler.sv
// Top level of the priority round-robin task scheduler.
// Depends on prrts_pkg and prrts_cell.
//
// channel   ports                          handshake
// request   req_operation .. req_sleep_ticks  start & !busy
// response  rsp_* fields                   rsp_valid, one cycle
// csr       csr_index, csr_wdata           csr_we
//
// Each word steps through decrement (on a tick only), scan, decide, apply and
// respond; the slot ring rotates once to scan and once to write back. Reset is
// synchronous and empties every slot.
// The response sits on the rsp_ ports for one cycle with rsp_valid and cannot
// be stalled; busy stays high until that cycle ends.
module priority_round_robin_task_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_task_id,
   input  logic [1:0]  req_priority_req,
   input  logic [31:0] req_sleep_ticks,
   output logic        rsp_valid,
   output logic        rsp_running_valid,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_switched,
   output logic        rsp_freed_valid,
   output logic [7:0]  rsp_freed_id,
   output logic        rsp_add_refused,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import prrts_pkg::*;

   localparam int IW = $clog2(MAX_TASKS);
   localparam logic [IW:0] NUM = (IW+1)'(MAX_TASKS);
   localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

   typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN, S_DECIDE, S_APPLY, S_RESP}
      state_type;

   state_type state_ff;
   logic [IW-1:0] idx_ff;
   logic [15:0] slice_high_ff, slice_normal_ff, slice_low_ff;

   // request word
   logic [2:0]  op_ff;
   logic [7:0]  id_ff;
   logic [1:0]  prio_ff;
   logic [31:0] sl_ff;

   // scheduler state
   logic [IW-1:0] ss_ff, ss_in, cur_ff, cur_in, cslot_ff;
   logic cv_ff, cv_in, rp_ff, rp_in;

   // scan results
   slot_type c_ff;
   logic [2:0] bf_ff;
   logic [IW-1:0] br_ff [3];
   logic [IW-1:0] bs_ff [3];
   logic [7:0] bt_ff [3];
   logic free_found_ff, rm_found_ff;
   logic [IW-1:0] free_slot_ff, rm_slot_ff, rm_rank_ff;

   // write-back plan
   logic cw_ff, cw_in, nw_ff, nw_in, aw_ff, aw_in, rw_ff, rw_in, cused_ff, cused_in;
   logic [1:0] cst_ff, cst_in;
   logic [31:0] ccnt_ff, ccnt_in;
   logic [IW-1:0] nslot_ff;

   // response
   logic rv_ff, rv_in, sw_ff, sw_in, fv_ff, fv_in, ref_ff, ref_in;
   logic [7:0] rid_ff, rid_in, fid_ff, fid_in;

   slot_type ring [MAX_TASKS];
   slot_type head, head_mod;
   cell_ctl_type ctl;
   logic [IW-1:0] rank;
   logic accept;

   assign accept = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign head = ring[0];
   assign ctl.shift = state_ff == S_SCAN || state_ff == S_APPLY;
   assign ctl.dec = state_ff == S_DEC;

   // distance of the head slot from the round-robin start
   always_comb begin
      if (idx_ff >= ss_ff) rank = idx_ff - ss_ff;
      else rank = IW'(({1'b0, idx_ff} + NUM) - {1'b0, ss_ff});
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      prrts_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .slot_prev((i == MAX_TASKS - 1) ? head_mod : ring[(i + 1) % MAX_TASKS]),
         .slot_out(ring[i])
      );
   end

   // write-back on the second rotation
   always_comb begin
      head_mod = head;
      if (state_ff == S_APPLY) begin
         if (aw_ff && idx_ff == free_slot_ff) begin
            head_mod.used = 1'b1;
            head_mod.task_id = id_ff;
            head_mod.prio = (prio_ff > PRIO_LOW) ? PRIO_LOW : prio_ff;
            head_mod.status = ST_READY;
            head_mod.count = 32'd0;
         end
         if (rw_ff && idx_ff == rm_slot_ff) head_mod.used = 1'b0;
         if (cw_ff && idx_ff == cslot_ff) begin
            head_mod.status = cst_ff;
            head_mod.count = ccnt_ff;
            head_mod.used = cused_ff;
         end
         if (nw_ff && idx_ff == nslot_ff) head_mod.status = ST_RUNNING;
      end
   end

   // decision after the scan
   logic n_found;
   logic [IW-1:0] n_slot;
   logic [7:0] n_task;
   logic [15:0] slice;
   logic [31:0] cnt1;

   always_comb begin
      n_found = 1'b0;
      n_slot = bs_ff[2];
      n_task = bt_ff[2];
      if (bf_ff[0]) begin
         n_found = 1'b1; n_slot = bs_ff[0]; n_task = bt_ff[0];
      end else if (bf_ff[1]) begin
         n_found = 1'b1; n_slot = bs_ff[1]; n_task = bt_ff[1];
      end else if (bf_ff[2]) begin
         n_found = 1'b1;
      end
      if (c_ff.prio == PRIO_HIGH) slice = slice_high_ff;
      else if (c_ff.prio == PRIO_LOW) slice = slice_low_ff;
      else slice = slice_normal_ff;
      cnt1 = c_ff.count + 32'd1;

      cv_in = cv_ff; cur_in = cur_ff; rp_in = rp_ff; ss_in = ss_ff;
      cw_in = 1'b0; nw_in = 1'b0; aw_in = 1'b0; rw_in = 1'b0;
      cst_in = c_ff.status; ccnt_in = c_ff.count; cused_in = 1'b1;
      fv_in = 1'b0; fid_in = 8'd0; ref_in = 1'b0;

      unique case (op_ff)
         OP_TICK: begin
            if (n_found) ss_in = (n_slot == LAST) ? '0 : n_slot + 1'b1;
            if (!cv_ff) begin
               if (n_found) begin
                  nw_in = 1'b1; cur_in = n_slot; cv_in = 1'b1;
               end
            end else if (c_ff.status == ST_EXITING || rp_ff) begin
               rp_in = 1'b0;
               cw_in = 1'b1;
               if (c_ff.status != ST_BLOCKED) ccnt_in = 32'd0;
               if (n_found) begin
                  if (c_ff.status == ST_RUNNING) cst_in = ST_READY;
                  nw_in = 1'b1; cur_in = n_slot;
               end else if (c_ff.status != ST_RUNNING) begin
                  cv_in = 1'b0;
               end
               if (c_ff.status == ST_EXITING) begin
                  cused_in = 1'b0; fv_in = 1'b1; fid_in = c_ff.task_id;
               end
            end else begin
               cw_in = 1'b1;
               if (cnt1 >= {16'd0, slice}) begin
                  ccnt_in = 32'd0;
                  if (n_found) begin
                     if (c_ff.status == ST_RUNNING) cst_in = ST_READY;
                     nw_in = 1'b1; cur_in = n_slot;
                  end
               end else begin
                  ccnt_in = cnt1;
               end
            end
         end
         OP_ADD: begin
            if (free_found_ff) aw_in = 1'b1;
            else ref_in = 1'b1;
         end
         OP_REMOVE: begin
            if (rm_found_ff) begin
               rw_in = 1'b1;
               if (cv_ff && rm_slot_ff == cur_ff) cv_in = 1'b0;
            end
         end
         OP_YIELD: rp_in = 1'b1;
         OP_SLEEP: begin
            if (cv_ff) begin
               cw_in = 1'b1; cst_in = ST_BLOCKED; ccnt_in = sl_ff; rp_in = 1'b1;
            end
         end
         OP_EXIT: begin
            if (cv_ff) begin
               cw_in = 1'b1; cst_in = ST_EXITING; rp_in = 1'b1;
            end
         end
         default: ;
      endcase

      rv_in = cv_in;
      rid_in = cv_in ? (nw_in ? n_task : c_ff.task_id) : 8'd0;
      sw_in = (cv_ff != cv_in) || (cv_in && cur_in != cur_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         ss_ff <= '0; cur_ff <= '0; cv_ff <= 1'b0; rp_ff <= 1'b0;
         slice_high_ff <= 16'd10; slice_normal_ff <= 16'd20; slice_low_ff <= 16'd40;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLICE_HIGH:   slice_high_ff <= csr_wdata;
               CSR_SLICE_NORMAL: slice_normal_ff <= csr_wdata;
               CSR_SLICE_LOW:    slice_low_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff <= req_operation; id_ff <= req_task_id;
                  prio_ff <= req_priority_req; sl_ff <= req_sleep_ticks;
                  bf_ff <= '0; free_found_ff <= 1'b0; rm_found_ff <= 1'b0;
                  idx_ff <= '0;
                  state_ff <= (req_operation == OP_TICK) ? S_DEC : S_SCAN;
               end
            end
            S_DEC: state_ff <= S_SCAN;
            S_SCAN: begin
               if (idx_ff == cur_ff) c_ff <= head;
               for (int p = 0; p < 3; p++) begin
                  if (head.used && head.status == ST_READY && head.prio == 2'(p) &&
                      (!bf_ff[p] || rank < br_ff[p])) begin
                     bf_ff[p] <= 1'b1; br_ff[p] <= rank;
                     bs_ff[p] <= idx_ff; bt_ff[p] <= head.task_id;
                  end
               end
               if (!head.used && !free_found_ff) begin
                  free_found_ff <= 1'b1; free_slot_ff <= idx_ff;
               end
               if (head.used && head.task_id == id_ff &&
                   (!rm_found_ff || rank < rm_rank_ff)) begin
                  rm_found_ff <= 1'b1; rm_slot_ff <= idx_ff; rm_rank_ff <= rank;
               end
               idx_ff <= (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
               if (idx_ff == LAST) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               cv_ff <= cv_in; cur_ff <= cur_in; rp_ff <= rp_in; ss_ff <= ss_in;
               cslot_ff <= cur_ff; nslot_ff <= n_slot;
               cw_ff <= cw_in; nw_ff <= nw_in; aw_ff <= aw_in; rw_ff <= rw_in;
               cst_ff <= cst_in; ccnt_ff <= ccnt_in; cused_ff <= cused_in;
               rv_ff <= rv_in; rid_ff <= rid_in; sw_ff <= sw_in;
               fv_ff <= fv_in; fid_ff <= fid_in; ref_ff <= ref_in;
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               idx_ff <= (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
               if (idx_ff == LAST) state_ff <= S_RESP;
            end
            S_RESP: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = state_ff == S_RESP;
   assign rsp_running_valid = rv_ff;
   assign rsp_running_id = rid_ff;
   assign rsp_switched = sw_ff;
   assign rsp_freed_valid = fv_ff;
   assign rsp_freed_id = fid_ff;
   assign rsp_add_refused = ref_ff;
endmodule

>>> design/prrts_cell.sv
// One task slot of the rotating slot ring.
// Depends on prrts_pkg.
module prrts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  prrts_pkg::cell_ctl_type ctl,
   input  prrts_pkg::slot_type     slot_prev,
   output prrts_pkg::slot_type     slot_out
);
   import prrts_pkg::*;

   slot_type slot_ff, slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.shift) begin
         slot_in = slot_prev;
      end else if (ctl.dec && slot_ff.used && slot_ff.status == ST_BLOCKED &&
                   slot_ff.count != 32'd0) begin
         slot_in.count = slot_ff.count - 32'd1;
         if (slot_ff.count == 32'd1) slot_in.status = ST_READY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff <= '0;
      else slot_ff <= slot_in;
   end

   assign slot_out = slot_ff;
endmodule

>>> design/prrts_checker.sv
// Port-level checks for the task scheduler, bound to the top level.
// Depends on priority_round_robin_task_scheduler_assert.svh.
`include "priority_round_robin_task_scheduler_assert.svh"
module prrts_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_running_valid,
   input logic [7:0] rsp_running_id,
   input logic       rsp_freed_valid,
   input logic [7:0] rsp_freed_id
);
   `PRRTS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `PRRTS_ASSERT_NEXT(a_one_cycle, clock, reset, rsp_valid, !rsp_valid && !busy)
   `PRRTS_ASSERT_NOW(a_resp_busy, clock, reset, rsp_valid, busy)
   `PRRTS_ASSERT_NOW(a_idle_id, clock, reset, rsp_valid && !rsp_running_valid,
      rsp_running_id == 8'd0 && (rsp_freed_valid || rsp_freed_id == 8'd0))
endmodule

bind priority_round_robin_task_scheduler prrts_checker u_prrts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_running_valid(rsp_running_valid),
   .rsp_running_id(rsp_running_id), .rsp_freed_valid(rsp_freed_valid),
   .rsp_freed_id(rsp_freed_id)
);

>>> verif/priority_round_robin_task_scheduler_tb.sv
// Self-checking bench for the priority round-robin task scheduler: a behavioural
// scheduler model predicts every response word, which is checked field by field.
// Depends on prrts_pkg and the priority_round_robin_task_scheduler RTL.
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_tb;
   import prrts_pkg::*;

   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] OP_BAD_A = 3'd6;
   localparam logic [2:0] OP_BAD_B = 3'd7;
   localparam logic [1:0] PRIO_NORMAL = 2'd1;
   localparam logic [1:0] PRIO_ODD = 2'd3;

   typedef struct packed {
      logic       running_valid;
      logic [7:0] running_id;
      logic       switched;
      logic       freed_valid;
      logic [7:0] freed_id;
      logic       add_refused;
   } sched_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [7:0]  req_task_id = '0;
   logic [1:0]  req_priority_req = '0;
   logic [31:0] req_sleep_ticks = '0;
   logic        rsp_valid;
   logic        rsp_running_valid;
   logic [7:0]  rsp_running_id;
   logic        rsp_switched;
   logic        rsp_freed_valid;
   logic [7:0]  rsp_freed_id;
   logic        rsp_add_refused;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // model state
   logic        m_used[NSLOT];
   logic [7:0]  m_id[NSLOT];
   logic [1:0]  m_prio[NSLOT];
   logic [1:0]  m_stat[NSLOT];
   logic [31:0] m_cnt[NSLOT];
   int unsigned m_scan, m_cur;
   logic        m_cur_ok, m_resched;
   logic [15:0] m_slice[3];

   sched_word_type expected_words[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  no_gaps = 1'b0;

   priority_round_robin_task_scheduler DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // response checker: each strobed word against the oldest prediction
   always @(posedge clock) begin
      sched_word_type w;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_running_valid !== w.running_valid)
               report_mismatch("running_valid", rsp_running_valid, w.running_valid);
            if (rsp_running_id !== w.running_id)
               report_mismatch("running_id", rsp_running_id, w.running_id);
            if (rsp_switched !== w.switched)
               report_mismatch("switched", rsp_switched, w.switched);
            if (rsp_freed_valid !== w.freed_valid)
               report_mismatch("freed_valid", rsp_freed_valid, w.freed_valid);
            if (rsp_freed_id !== w.freed_id)
               report_mismatch("freed_id", rsp_freed_id, w.freed_id);
            if (rsp_add_refused !== w.add_refused)
               report_mismatch("add_refused", rsp_add_refused, w.add_refused);
         end
      end
   end

   function automatic void model_reset();
      for (int i = 0; i < NSLOT; i++) begin
         m_used[i] = 0; m_id[i] = 0; m_prio[i] = 0; m_stat[i] = ST_READY; m_cnt[i] = 0;
      end
      m_scan = 0; m_cur = 0; m_cur_ok = 0; m_resched = 0;
      m_slice[0] = 16'd10; m_slice[1] = 16'd20; m_slice[2] = 16'd40;
   endfunction

   // highest priority ready slot, round robin from the scan pointer; -1 if none
   function automatic int choose_ready();
      int s;
      for (int p = 0; p <= 2; p++)
         for (int i = 0; i < NSLOT; i++) begin
            s = (m_scan + i) % NSLOT;
            if (m_used[s] && m_stat[s] == ST_READY && m_prio[s] == p) begin
               m_scan = (s + 1) % NSLOT;
               return s;
            end
         end
      return -1;
   endfunction

   function automatic void dispatch(input int s);
      if (m_cur_ok && m_stat[m_cur] == ST_RUNNING) m_stat[m_cur] = ST_READY;
      m_cur = s; m_cur_ok = 1; m_stat[s] = ST_RUNNING;
   endfunction

   function automatic void tick_model(ref logic fv, ref logic [7:0] fid);
      int n;
      int unsigned c;
      logic dying;
      logic [15:0] sl;
      for (int i = 0; i < NSLOT; i++)
         if (m_used[i] && m_stat[i] == ST_BLOCKED && m_cnt[i] != 0) begin
            m_cnt[i]--;
            if (m_cnt[i] == 0) m_stat[i] = ST_READY;
         end
      n = choose_ready();
      if (!m_cur_ok) begin
         if (n >= 0) dispatch(n);
         return;
      end
      c = m_cur;
      if (m_stat[c] == ST_EXITING || m_resched) begin
         dying = (m_stat[c] == ST_EXITING);
         m_resched = 0;
         if (m_stat[c] != ST_BLOCKED) m_cnt[c] = 0;
         if (n >= 0) dispatch(n);
         else if (m_stat[c] != ST_RUNNING) m_cur_ok = 0;
         if (dying) begin
            m_used[c] = 0; fv = 1; fid = m_id[c];
            if (m_cur_ok && m_cur == c) m_cur_ok = 0;
         end
         return;
      end
      m_cnt[c]++;
      sl = (m_prio[c] == PRIO_HIGH) ? m_slice[0] : (m_prio[c] == PRIO_LOW) ? m_slice[2]
                                                                        : m_slice[1];
      if (m_cnt[c] >= {16'd0, sl}) begin
         m_cnt[c] = 0;
         if (n >= 0) dispatch(n);
      end
   endfunction

   function automatic sched_word_type predict_event(input logic [2:0] op,
                                                    input logic [7:0] id,
                                                    input logic [1:0] pr,
                                                    input logic [31:0] sl);
      sched_word_type w;
      logic was_ok = m_cur_ok;
      int unsigned was_cur = m_cur;
      logic fv = 0, refused = 0;
      logic [7:0] fid = 0;
      int s;
      case (op)
         OP_TICK: tick_model(fv, fid);
         OP_ADD: begin
            refused = 1;
            for (int i = 0; i < NSLOT; i++)
               if (refused && !m_used[i]) begin
                  m_used[i] = 1; m_id[i] = id; m_prio[i] = (pr > PRIO_LOW) ? PRIO_LOW : pr;
                  m_stat[i] = ST_READY; m_cnt[i] = 0; refused = 0;
               end
         end
         OP_REMOVE: begin
            for (int i = 0; i < NSLOT; i++) begin
               s = (m_scan + i) % NSLOT;
               if (m_used[s] && m_id[s] == id) begin
                  m_used[s] = 0;
                  if (m_cur_ok && m_cur == s) m_cur_ok = 0;
                  break;
               end
            end
         end
         OP_YIELD: m_resched = 1;
         OP_SLEEP: if (m_cur_ok) begin
            m_cnt[m_cur] = sl; m_stat[m_cur] = ST_BLOCKED; m_resched = 1;
         end
         OP_EXIT: if (m_cur_ok) begin
            m_stat[m_cur] = ST_EXITING; m_resched = 1;
         end
         default: ;
      endcase
      w.running_valid = m_cur_ok;
      w.running_id = m_cur_ok ? m_id[m_cur] : 8'd0;
      w.switched = (was_ok != m_cur_ok) || (m_cur_ok && was_cur != m_cur);
      w.freed_valid = fv;
      w.freed_id = fv ? fid : 8'd0;
      w.add_refused = refused;
      return w;
   endfunction

   // one request word: at least one falling edge, optional gap, then drive and wait
   task automatic send_event(input logic [2:0] op, input logic [7:0] id = 0,
                             input logic [1:0] pr = 0, input logic [31:0] sl = 0);
      do @(negedge clock); while (!no_gaps && $urandom_range(99) < 9);
      start <= 1'b1;
      req_operation <= op; req_task_id <= id; req_priority_req <= pr; req_sleep_ticks <= sl;
      do @(posedge clock); while (busy);
      expected_words.push_back(predict_event(op, id, pr, sl));
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (2 * NSLOT + 8) @(negedge clock);
   endtask

   task automatic write_slice(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      m_slice[idx] = val;
   endtask

   task automatic ticks(input int n);
      repeat (n) send_event(OP_TICK);
   endtask

   // directed: add extremes, full table, odd priority, lone yield, sleeps, exit
   task automatic test_directed();
      send_event(OP_SLEEP, 0, 0, 32'd5);           // no task: ignored
      send_event(OP_EXIT);
      send_event(OP_YIELD);                        // recorded without a task
      send_event(OP_ADD, 8'hFF, PRIO_ODD);
      send_event(OP_TICK);
      send_event(OP_TICK);                         // lone yield keeps it running
      send_event(OP_ADD, 8'h00, PRIO_HIGH);
      send_event(OP_ADD, 8'h5A, PRIO_NORMAL);
      send_event(OP_TICK);
      send_event(OP_SLEEP, 0, 0, 32'd2);
      ticks(3);
      send_event(OP_SLEEP, 0, 0, 32'hFFFF_FFFF);
      send_event(OP_TICK);
      send_event(OP_EXIT);
      send_event(OP_TICK);
      send_event(OP_BAD_A);
      send_event(OP_BAD_B);
      send_event(OP_REMOVE, 8'h77);                // no match
      for (int i = 0; i < NSLOT - 1; i++) send_event(OP_ADD, 8'(i + 16), 2'(i % 3));
      send_event(OP_ADD, 8'hAA, PRIO_HIGH);        // table full
      send_event(OP_REMOVE, 8'hFF);
   endtask

   // slice expiry at both extremes of the slice registers
   task automatic test_slices(input logic [15:0] val);
      drain();
      write_slice(CSR_SLICE_HIGH, val);
      write_slice(CSR_SLICE_NORMAL, val);
      write_slice(CSR_SLICE_LOW, val);
      ticks(6);
   endtask

   // random: mostly tick/add/remove/yield/sleep/exit with plausible values
   task automatic test_random(input int n);
      logic [2:0] op;
      logic [31:0] sl;
      logic [7:0] id;
      int r;
      for (int k = 0; k < n; k++) begin
         no_gaps = (k >= n / 3 && k < n / 2);
         r = $urandom_range(99);
         op = r < 40 ? OP_TICK : r < 58 ? OP_ADD : r < 70 ? OP_REMOVE : r < 80 ? OP_YIELD :
              r < 89 ? OP_SLEEP : r < 97 ? OP_EXIT : 3'($urandom_range(7, 6));
         id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(31));
         r = $urandom_range(9);
         sl = r < 7 ? $urandom_range(6) : r < 9 ? $urandom : 32'd0;
         send_event(op, id, 2'($urandom), sl);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_slices(16'd1);
      test_slices(16'hFFFF);
      drain();
      write_slice(CSR_SLICE_HIGH, 16'd3);
      write_slice(CSR_SLICE_NORMAL, 16'd5);
      write_slice(CSR_SLICE_LOW, 16'd8);
      test_random(400);
      drain();
      write_slice(CSR_SLICE_HIGH, 16'd0);          // expires every tick
      write_slice(CSR_SLICE_LOW, 16'd2);
      test_random(200);
      drain();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
